>>> rtl/core/assert_macros.svh
// assert_macros.svh: assertion macros shared by the score keeper RTL.
// No dependencies. The bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define TKSK_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
// expression must never be true out of reset
`define TKSK_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define TKSK_ASSERT(lbl, clk, rst_n, prop)
`define TKSK_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

>>> rtl/core/tksk_pkg.sv
// tksk_pkg: types, sizes and helpers for the top-k score keeper.
// No dependencies; used by every module of the block.
package tksk_pkg;

  // built depth of the cell row
  localparam int Depth  = 16;
  localparam int IdxW   = $clog2(Depth);
  localparam int CountW = $clog2(Depth + 1);
  localparam int ScoreW = 32;
  localparam int TagW   = 32;
  localparam int RankW  = 4;
  localparam int CfgW   = 5;
  localparam int AddrW  = 3;
  localparam int DataW  = 32;

  // register index and reset value
  localparam logic RegListSize = 1'b0;
  localparam logic [CfgW-1:0] ListSizeRst = CfgW'(16);

  // operation codes
  localparam logic OpInsert = 1'b0;
  localparam logic OpDump   = 1'b1;

  typedef logic signed [ScoreW-1:0] score_t;
  typedef logic [TagW-1:0] tag_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [IdxW-1:0] idx_t;

  // data handed from one cell to the next
  typedef struct packed {
    logic   beat;   // this cell loses its place to the candidate
    score_t score;
    tag_t   tag;
  } link_t;

  // per-cell control from the row
  typedef struct packed {
    logic insert_en;
    logic in_span;
    logic is_span;
  } cell_ctl_t;

  // insert outcome reported by the row
  typedef struct packed {
    logic   accepted;
    count_t count_next;
  } ins_stat_t;

  // strict signed compare, a below b
  function automatic logic score_less(score_t a, score_t b);
    return a < b;
  endfunction

endpackage

>>> rtl/core/top_k_score_keeper_top.sv
// top_k_score_keeper_top: top level with APB register, dump sequencer, output register.
// Depends on tksk_pkg, tksk_chain and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: an insert
//   (operation 0) of a Q16.16 score and a tag, or a dump (operation 1).
//   Output channel (out_valid_o / out_stall_i) returns results from one
//   output register.
//   An insert gives one result (accepted, kept_count, last=1) in the cycle after
//   acceptance; the cell row compares all slots in parallel and shifts in place,
//   so inserts are taken one per cycle while the output is not stalled.
//   A dump gives kept_count results in rank order, one per cycle while the output
//   is not stalled, read through the single read port of the row in the dump
//   state. An empty list gives one result with entry_valid 0 in the cycle
//   after acceptance. No new request is taken until the last result of a
//   dump is loaded.
//   A stalled output holds its result and back-pressures the input.
//   Reset clears the list (kept_count 0) and sets list_size to 16.
//   list_size lives at byte address 0 of the APB port; write it only
//   while the block is idle.
`include "assert_macros.svh"
module top_k_score_keeper_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tksk_pkg::AddrW-1:0]    paddr,
  input  logic [tksk_pkg::DataW-1:0]    pwdata,
  output logic [tksk_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic signed [tksk_pkg::ScoreW-1:0] candidate_score_i,
  input  logic [tksk_pkg::TagW-1:0]     candidate_tag_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          accepted_o,
  output logic                          entry_valid_o,
  output logic signed [tksk_pkg::ScoreW-1:0] entry_score_o,
  output logic [tksk_pkg::TagW-1:0]     entry_tag_o,
  output logic [tksk_pkg::RankW-1:0]    entry_rank_o,
  output logic [tksk_pkg::CountW-1:0]   kept_count_o,
  output logic                          last_o
);
  import tksk_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic [CfgW-1:0] list_size_q;
  idx_t   idx_q, idx_d;
  logic   in_acc, load_ok, cfg_wr, dump_last;
  score_t rd_score;
  tag_t   rd_tag;
  count_t count;
  ins_stat_t stat;

  // output register
  logic   out_valid_q, out_valid_d;
  logic   acc_q, acc_d, ev_q, ev_d, last_q, last_d;
  score_t score_q, score_d;
  tag_t   tag_q, tag_d;
  logic [RankW-1:0] rank_q, rank_d;
  count_t kc_q, kc_d;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegListSize);
  assign prdata = DataW'(list_size_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_size_q <= ListSizeRst;
    end else if (cfg_wr) begin
      list_size_q <= pwdata[CfgW-1:0];
    end
  end

  // handshake
  assign load_ok    = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !load_ok;
  assign in_acc     = in_valid_i && !in_stall_o;

  tksk_chain u_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .insert_i     (in_acc && (operation_i == OpInsert)),
    .cand_score_i (candidate_score_i),
    .cand_tag_i   (candidate_tag_i),
    .list_size_i  (list_size_q),
    .rd_idx_i     (idx_q),
    .rd_score_o   (rd_score),
    .rd_tag_o     (rd_tag),
    .count_o      (count),
    .stat_o       (stat)
  );

  assign dump_last = (count_t'(idx_q) + count_t'(1)) == count;

  // dump sequencer and result selection
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    acc_d       = acc_q;
    ev_d        = ev_q;
    score_d     = score_q;
    tag_d       = tag_q;
    rank_d      = rank_q;
    kc_d        = kc_q;
    last_d      = last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (operation_i == OpInsert) begin
            out_valid_d = 1'b1;
            acc_d       = stat.accepted;
            ev_d        = 1'b0;
            score_d     = '0;
            tag_d       = '0;
            rank_d      = '0;
            kc_d        = stat.count_next;
            last_d      = 1'b1;
          end else if (count == '0) begin
            out_valid_d = 1'b1;
            acc_d       = 1'b0;
            ev_d        = 1'b0;
            score_d     = '0;
            tag_d       = '0;
            rank_d      = '0;
            kc_d        = '0;
            last_d      = 1'b1;
          end else begin
            state_d = ST_DUMP;
            idx_d   = '0;
          end
        end
      end
      ST_DUMP: begin
        if (load_ok) begin
          out_valid_d = 1'b1;
          acc_d       = 1'b0;
          ev_d        = 1'b1;
          score_d     = rd_score;
          tag_d       = rd_tag;
          rank_d      = RankW'(idx_q);
          kc_d        = count;
          last_d      = dump_last;
          if (dump_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + idx_t'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    ev_q    <= ev_d;
    score_q <= score_d;
    tag_q   <= tag_d;
    rank_q  <= rank_d;
    kc_q    <= kc_d;
    last_q  <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign accepted_o    = acc_q;
  assign entry_valid_o = ev_q;
  assign entry_score_o = score_q;
  assign entry_tag_o   = tag_q;
  assign entry_rank_o  = rank_q;
  assign kept_count_o  = kc_q;
  assign last_o        = last_q;

  `TKSK_ASSERT(a_dump_blocks_input, clk_i, rst_ni, (state_q == ST_DUMP) |-> in_stall_o)
  `TKSK_ASSERT(a_dump_idx_range, clk_i, rst_ni, (state_q == ST_DUMP) |-> (count_t'(idx_q) < count))
  `TKSK_ASSERT_NEVER(a_acc_and_entry, clk_i, rst_ni, out_valid_q && acc_q && ev_q)

endmodule

>>> rtl/core/tksk_cell.sv
// tksk_cell: one slot of the sorted row, holding a score and a tag.
// Depends on tksk_pkg.
module tksk_cell (
  input  logic                clk_i,
  input  tksk_pkg::cell_ctl_t ctl_i,
  input  tksk_pkg::score_t    cand_score_i,
  input  tksk_pkg::tag_t      cand_tag_i,
  input  tksk_pkg::link_t     prev_i,
  output tksk_pkg::link_t     next_o,
  output logic                cand_below_o
);
  import tksk_pkg::*;

  score_t score_q, score_d;
  tag_t   tag_q, tag_d;
  logic   beat;

  // the first cell of the span whose score is below the candidate, or else the span's last cell, takes it
  assign beat = ctl_i.in_span && (ctl_i.is_span || score_less(score_q, cand_score_i));
  assign cand_below_o = score_less(cand_score_i, score_q);

  // shift down behind the insertion point, load candidate at it
  always_comb begin
    score_d = score_q;
    tag_d   = tag_q;
    if (ctl_i.insert_en && ctl_i.in_span) begin
      if (prev_i.beat) begin
        score_d = prev_i.score;
        tag_d   = prev_i.tag;
      end else if (beat) begin
        score_d = cand_score_i;
        tag_d   = cand_tag_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    tag_q   <= tag_d;
  end

  assign next_o = '{beat: beat, score: score_q, tag: tag_q};

endmodule

>>> rtl/core/tksk_chain.sv
// tksk_chain: row of tksk_cell slots with entry count and accept logic.
// Depends on tksk_pkg, tksk_cell and assert_macros.svh.
`include "assert_macros.svh"
module tksk_chain (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    insert_i,
  input  tksk_pkg::score_t        cand_score_i,
  input  tksk_pkg::tag_t          cand_tag_i,
  input  logic [tksk_pkg::CfgW-1:0] list_size_i,
  input  tksk_pkg::idx_t          rd_idx_i,
  output tksk_pkg::score_t        rd_score_o,
  output tksk_pkg::tag_t          rd_tag_o,
  output tksk_pkg::count_t        count_o,
  output tksk_pkg::ins_stat_t     stat_o
);
  import tksk_pkg::*;

  count_t    count_q, count_d;
  count_t    size_eff, span;
  logic      full, reject, all_below, do_ins;
  link_t     links [Depth+1];
  cell_ctl_t ctl [Depth];
  logic [Depth-1:0] cand_below;
  logic [Depth-1:0] occ;

  // list size clamped to 1..Depth
  always_comb begin
    priority if (list_size_i == '0) begin
      size_eff = count_t'(1);
    end else if (int'(list_size_i) > Depth) begin
      size_eff = count_t'(Depth);
    end else begin
      size_eff = count_t'(list_size_i);
    end
  end

  assign full = count_q >= size_eff;
  // when full the lowest entry drops out, so it joins the span end
  assign span = full ? count_q - count_t'(1) : count_q;

  // rejected when below every kept score while full
  assign all_below = &(cand_below | ~occ);
  assign reject    = full && all_below;
  assign do_ins    = insert_i && !reject;

  assign links[0] = '{beat: 1'b0, score: '0, tag: '0};

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    assign occ[i] = count_t'(i) < count_q;
    assign ctl[i] = '{insert_en: do_ins,
                      in_span:   count_t'(i) <= span,
                      is_span:   count_t'(i) == span};
    tksk_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl[i]),
      .cand_score_i (cand_score_i),
      .cand_tag_i   (cand_tag_i),
      .prev_i       (links[i]),
      .next_o       (links[i+1]),
      .cand_below_o (cand_below[i])
    );
  end

  // entry count grows only while not full
  assign count_d = (do_ins && !full) ? count_q + count_t'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // read port for dumps
  always_comb begin
    rd_score_o = '0;
    rd_tag_o   = '0;
    for (int i = 0; i < Depth; i++) begin
      if (idx_t'(i) == rd_idx_i) begin
        rd_score_o = links[i+1].score;
        rd_tag_o   = links[i+1].tag;
      end
    end
  end

  assign count_o = count_q;
  assign stat_o  = '{accepted: !reject, count_next: count_d};

  `TKSK_ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q > count_t'(Depth))
  `TKSK_ASSERT(a_reject_hold, clk_i, rst_ni, (insert_i && reject) |=> $stable(count_q))
  `TKSK_ASSERT(a_no_grow_full, clk_i, rst_ni, (insert_i && full) |=> $stable(count_q))
  for (genvar i = 1; i < Depth; i++) begin : g_sorted
    `TKSK_ASSERT(a_sorted, clk_i, rst_ni, (count_t'(i) < count_q) |-> !score_less(links[i].score, links[i+1].score))
  end

endmodule
